FILE: sv/lis_pkg.sv
// Shared types, constants and next-state functions of the LED indicator sequencer.
package lis_pkg;

   // Defaults for the top-level parameters
   localparam int LIS_NUM_INDICATIONS = 7;
   localparam int LIS_FLASH_STEP_MS   = 80;

   // Field and state widths
   localparam int LIS_OP_W     = 3;
   localparam int LIS_IND_W    = 3;
   localparam int LIS_SET_W    = 7;
   localparam int LIS_MASK_W   = 8;
   localparam int LIS_COUNT_W  = 8;
   localparam int LIS_SECS_W   = 16;
   localparam int LIS_HUE_W    = 3;
   localparam int LIS_ON_W     = 8;
   localparam int LIS_BLINK_W  = 13;
   localparam int LIS_IDENT_W  = 26;
   localparam int LIS_REQ_W    = 32;
   localparam int LIS_RSP_W    = 8;

   // Operation codes
   localparam logic [LIS_OP_W-1:0] OP_TICK     = 3'd0;
   localparam logic [LIS_OP_W-1:0] OP_SET      = 3'd1;
   localparam logic [LIS_OP_W-1:0] OP_FLASH    = 3'd2;
   localparam logic [LIS_OP_W-1:0] OP_IDENTIFY = 3'd3;
   localparam logic [LIS_OP_W-1:0] OP_ENABLE   = 3'd4;

   // Colour bits
   localparam logic [LIS_HUE_W-1:0] C_RED   = 3'h1;
   localparam logic [LIS_HUE_W-1:0] C_GREEN = 3'h2;
   localparam logic [LIS_HUE_W-1:0] C_BLUE  = 3'h4;

   localparam logic [LIS_IND_W-1:0]   LIS_IDENT_INDEX = 3'd6;
   localparam logic [LIS_IDENT_W-1:0] LIS_MS_PER_S    = 26'd1000;
   localparam logic [LIS_COUNT_W-1:0] LIS_COUNT_MAX   = 8'd255;

   // Input beat, operation in the lowest bits
   typedef struct packed {
      logic                   enable_value;
      logic [LIS_SECS_W-1:0]  identify_seconds;
      logic [LIS_COUNT_W-1:0] flash_count;
      logic                   activate;
      logic [LIS_IND_W-1:0]   indication;
      logic [LIS_OP_W-1:0]    operation;
   } lis_req_type;

   // Result beat, colour in the lowest bits
   typedef struct packed {
      logic                 pad;
      logic [LIS_IND_W-1:0] shown_indication;
      logic                 lit;
      logic [LIS_HUE_W-1:0] colour;
   } lis_rsp_type;

   typedef struct packed {
      logic [LIS_SET_W-1:0]   active_set;
      logic                   light_phase;
      logic [LIS_COUNT_W-1:0] flashes_left;
      logic [LIS_HUE_W-1:0]   flash_hue;
      logic                   led_enabled;
      logic [LIS_BLINK_W-1:0] blink_wait_ms;
      logic                   blink_armed;
      logic [LIS_IDENT_W-1:0] identify_wait_ms;
      logic                   identify_armed;
      logic [LIS_HUE_W-1:0]   driven_colour;
   } lis_state_type;

   localparam lis_state_type LIS_STATE_RESET = '{
      active_set: '0, light_phase: 1'b0, flashes_left: '0, flash_hue: '0,
      led_enabled: 1'b1, blink_wait_ms: '0, blink_armed: 1'b0,
      identify_wait_ms: '0, identify_armed: 1'b0, driven_colour: '0};

   typedef struct packed {
      logic [LIS_HUE_W-1:0]   hue;
      logic [LIS_ON_W-1:0]    on_ms;
      logic [LIS_BLINK_W-1:0] cycle_ms;
   } lis_look_type;

   // Colour and timing of each indication
   function automatic lis_look_type look_of(logic [LIS_IND_W-1:0] idx);
      lis_look_type lk;
      unique case (idx)
         3'd1:    lk = '{hue: C_BLUE,                  on_ms: 8'd30,  cycle_ms: 13'd2000};
         3'd2:    lk = '{hue: C_RED | C_GREEN,         on_ms: 8'd100, cycle_ms: 13'd500};
         3'd3:    lk = '{hue: C_GREEN,                 on_ms: 8'd20,  cycle_ms: 13'd5000};
         3'd4:    lk = '{hue: C_RED | C_BLUE,          on_ms: 8'd100, cycle_ms: 13'd300};
         3'd5:    lk = '{hue: C_RED,                   on_ms: 8'd100, cycle_ms: 13'd1000};
         3'd6:    lk = '{hue: C_RED | C_GREEN | C_BLUE, on_ms: 8'd250, cycle_ms: 13'd500};
         default: lk = '0;
      endcase
      return lk;
   endfunction

   // Indications that exist for a given indication count; index 7 never does
   function automatic logic [LIS_MASK_W-1:0] ind_mask(int num);
      logic [LIS_MASK_W-1:0] m;
      m = '0;
      for (int i = 0; i < LIS_SET_W; i++) begin
         m[i] = (i < num);
      end
      return m;
   endfunction

   // Highest active indication, 0 when none
   function automatic logic [LIS_IND_W-1:0] top_index(logic [LIS_SET_W-1:0] act,
                                                      logic [LIS_MASK_W-1:0] mask);
      logic [LIS_IND_W-1:0] r;
      r = '0;
      for (int i = 1; i < LIS_SET_W; i++) begin
         if (act[i] && mask[i]) begin
            r = LIS_IND_W'(i);
         end
      end
      return r;
   endfunction

   // One step of the blink or flash pattern
   function automatic lis_state_type blink_step(lis_state_type s,
                                                logic [LIS_MASK_W-1:0] mask,
                                                logic [LIS_BLINK_W-1:0] flash_step);
      lis_state_type        r;
      logic [LIS_IND_W-1:0] idx;
      lis_look_type         lk;
      r = s;
      idx = top_index(s.active_set, mask);
      lk = look_of(idx);
      r.blink_armed = 1'b0;
      if (!s.led_enabled) begin
         r.driven_colour = '0;
      end else if (s.flashes_left != '0) begin
         r.light_phase   = !s.light_phase;
         r.driven_colour = r.light_phase ? s.flash_hue : '0;
         r.flashes_left  = s.flashes_left - LIS_COUNT_W'(1);
         r.blink_wait_ms = flash_step;
         r.blink_armed   = 1'b1;
      end else if (idx == '0 || lk.cycle_ms == '0) begin
         r.light_phase   = 1'b0;
         r.driven_colour = '0;
      end else if (s.light_phase) begin
         r.light_phase   = 1'b0;
         r.driven_colour = '0;
         r.blink_wait_ms = lk.cycle_ms - LIS_BLINK_W'(lk.on_ms);
         r.blink_armed   = 1'b1;
      end else begin
         r.light_phase   = 1'b1;
         r.driven_colour = lk.hue;
         r.blink_wait_ms = LIS_BLINK_W'(lk.on_ms);
         r.blink_armed   = 1'b1;
      end
      return r;
   endfunction

   // Set or clear one indication and restart the pattern
   function automatic lis_state_type set_indication(lis_state_type s,
                                                    logic [LIS_IND_W-1:0] idx,
                                                    logic on,
                                                    logic [LIS_MASK_W-1:0] mask,
                                                    logic [LIS_BLINK_W-1:0] flash_step);
      lis_state_type         r;
      logic [LIS_MASK_W-1:0] bits;
      r = s;
      bits = {1'b0, s.active_set};
      if (mask[idx]) begin
         bits[idx] = on;
         r.active_set  = bits[LIS_SET_W-1:0];
         r.light_phase = 1'b0;
         r = blink_step(r, mask, flash_step);
      end
      return r;
   endfunction

endpackage

FILE: sv/lis_in_stage.sv
// Input register of the LED indicator sequencer: holds one request beat.
module lis_in_stage
   import lis_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [LIS_REQ_W-1:0] req_tdata,
   input  logic                 advance,
   output logic                 item_valid,
   output lis_req_type          item
);

   logic        valid_ff, valid_in;
   lis_req_type data_ff;

   // Take a new beat when empty or when the held one moves on
   assign req_tready = !valid_ff || advance;
   assign valid_in   = req_tvalid || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_tready) begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload while it waits
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         data_ff <= lis_req_type'(req_tdata);
      end
   end

   assign item_valid = valid_ff;
   assign item       = data_ff;

endmodule

FILE: sv/lis_core.sv
// State registers and next-state logic of the LED indicator sequencer.
module lis_core
   import lis_pkg::*;
#(
   parameter int NUM_INDICATIONS = LIS_NUM_INDICATIONS,
   parameter int FLASH_STEP_MS   = LIS_FLASH_STEP_MS
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  lis_req_type item,
   output lis_rsp_type result
);

   localparam logic [LIS_MASK_W-1:0]  IND_MASK   = ind_mask(NUM_INDICATIONS);
   localparam logic [LIS_BLINK_W-1:0] FLASH_STEP = LIS_BLINK_W'(FLASH_STEP_MS);

   lis_state_type              state_ff, state_in;
   logic                       reblinked;
   logic [LIS_COUNT_W:0]       twice;
   logic [LIS_IDENT_W-1:0]     ident_ms;
   lis_look_type               flash_look;

   assign twice      = {item.flash_count, 1'b0};
   assign ident_ms   = {{(LIS_IDENT_W-LIS_SECS_W){1'b0}}, item.identify_seconds} * LIS_MS_PER_S;
   assign flash_look = look_of(item.indication);

   // Apply one operation to the state
   always_comb begin
      state_in  = state_ff;
      reblinked = 1'b0;
      unique case (item.operation)
         OP_TICK: begin
            // Identify timer first; its expiry restarts the pattern itself
            if (state_in.identify_armed) begin
               if (state_in.identify_wait_ms <= LIS_IDENT_W'(1)) begin
                  state_in.identify_armed   = 1'b0;
                  state_in.identify_wait_ms = '0;
                  state_in = set_indication(state_in, LIS_IDENT_INDEX, 1'b0,
                                            IND_MASK, FLASH_STEP);
                  reblinked = IND_MASK[LIS_IDENT_INDEX];
               end else begin
                  state_in.identify_wait_ms = state_in.identify_wait_ms - LIS_IDENT_W'(1);
               end
            end
            if (!reblinked && state_in.blink_armed) begin
               if (state_in.blink_wait_ms <= LIS_BLINK_W'(1)) begin
                  state_in.blink_wait_ms = '0;
                  state_in = blink_step(state_in, IND_MASK, FLASH_STEP);
               end else begin
                  state_in.blink_wait_ms = state_in.blink_wait_ms - LIS_BLINK_W'(1);
               end
            end
         end
         OP_SET: begin
            state_in = set_indication(state_in, item.indication, item.activate,
                                      IND_MASK, FLASH_STEP);
         end
         OP_FLASH: begin
            if (state_in.led_enabled && IND_MASK[item.indication] &&
                item.flash_count != '0) begin
               state_in.flash_hue    = flash_look.hue;
               state_in.flashes_left = twice[LIS_COUNT_W] ? LIS_COUNT_MAX
                                                          : twice[LIS_COUNT_W-1:0];
               state_in.light_phase  = 1'b0;
               state_in = blink_step(state_in, IND_MASK, FLASH_STEP);
            end
         end
         OP_IDENTIFY: begin
            state_in = set_indication(state_in, LIS_IDENT_INDEX, 1'b1,
                                      IND_MASK, FLASH_STEP);
            if (item.identify_seconds == '0) begin
               state_in.identify_armed   = 1'b0;
               state_in.identify_wait_ms = '0;
               state_in = set_indication(state_in, LIS_IDENT_INDEX, 1'b0,
                                         IND_MASK, FLASH_STEP);
            end else begin
               state_in.identify_wait_ms = ident_ms;
               state_in.identify_armed   = 1'b1;
            end
         end
         OP_ENABLE: begin
            state_in.led_enabled = item.enable_value;
            if (!item.enable_value) begin
               state_in.flashes_left  = '0;
               state_in.light_phase   = 1'b0;
               state_in.driven_colour = '0;
            end else begin
               state_in = blink_step(state_in, IND_MASK, FLASH_STEP);
            end
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   // Commit state when the item moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LIS_STATE_RESET;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result describes the state after the item
   assign result.pad              = 1'b0;
   assign result.shown_indication = top_index(state_in.active_set, IND_MASK);
   assign result.lit              = state_in.light_phase;
   assign result.colour           = state_in.driven_colour;

endmodule

FILE: sv/led_indicator_sequencer_top.sv
// Top level of the LED indicator sequencer: input stage, core and result register.
//
// Usage: each request beat is a 1 ms tick or an event (set or clear an
// indication, acknowledgement flashes, identify window, LED enable). Every
// request beat produces exactly one response beat with the colour driven,
// the on-phase flag and the highest active indication after that request.
// Channels: req_* carries requests, rsp_* carries responses, both with
// tvalid/tready; a beat moves when both are high.
// The request passes through the input register and then the result
// register. Throughput: one beat per cycle while rsp_tready is high; the
// whole update is combinational logic between the two registers.
// Reset: synchronous, active high; the LED is enabled and dark, no
// indication is active and all timers are disarmed. Both channels empty.
// Stall: while rsp_tready is low the response holds; one more request is
// taken into the input register and then req_tready drops until the
// response moves on. State only advances when a response is produced.
module led_indicator_sequencer_top
   import lis_pkg::*;
#(
   parameter int NUM_INDICATIONS = LIS_NUM_INDICATIONS,
   parameter int FLASH_STEP_MS   = LIS_FLASH_STEP_MS
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // operation[2:0], indication[5:3], activate[6], flash_count[14:7],
   // identify_seconds[30:15], enable_value[31]
   input  logic [LIS_REQ_W-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // colour[2:0], lit[3], shown_indication[6:4], zero[7]
   output logic [LIS_RSP_W-1:0] rsp_tdata
);

   logic        item_valid;
   lis_req_type item;
   lis_rsp_type result;
   logic        advance;
   logic        rsp_valid_ff;
   lis_rsp_type rsp_data_ff;

   // Move the held item on when the result register is free
   assign advance = item_valid && (!rsp_valid_ff || rsp_tready);

   lis_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   lis_core #(
      .NUM_INDICATIONS (NUM_INDICATIONS),
      .FLASH_STEP_MS   (FLASH_STEP_MS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   // Result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = LIS_RSP_W'(rsp_data_ff);

endmodule

FILE: sv/lis_checker.sv
// Port-level assertions for the LED indicator sequencer and their binding.
module lis_checker
   import lis_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [LIS_RSP_W-1:0] rsp_tdata
);

   // Reset empties the response channel
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // Stalled response holds its beat
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // A free output never blocks requests
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request blocked while output free");

   // A colour is only driven in the on phase
   a_colour_lit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != 3'd0 |-> rsp_tdata[3])
      else $error("colour driven in off phase");

   // No indication above identify is ever shown
   a_shown_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[6:4] != 3'd7 && rsp_tdata[7] == 1'b0)
      else $error("shown indication out of range");

endmodule

bind led_indicator_sequencer_top lis_checker u_lis_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
